// ===== rtl/legendre_tensor_basis_eval_defines.svh =====
// Assertion macros shared by the RTL of the Legendre basis evaluator.
`ifndef LEGENDRE_TENSOR_BASIS_EVAL_DEFINES_SVH
`define LEGENDRE_TENSOR_BASIS_EVAL_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define LTBE_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("ltbe: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define LTBE_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("ltbe: next-cycle check failed");

`endif

// ===== rtl/ltbe_pkg.sv =====
// Shared types, constants and rounding helper of the Legendre basis evaluator.
package ltbe_pkg;

    localparam int MAX_ORDER   = 4;
    localparam int POLY_N      = MAX_ORDER + 1;
    localparam int POLY_SEL_W  = $clog2(POLY_N);
    localparam int ORDER_W     = 3;
    localparam int IDX_W       = 4;
    localparam int COORD_W     = 16;
    localparam int OUT_W       = 24;
    localparam int VAL_W       = 31;
    localparam int DER_W       = 34;
    localparam int WORK_W      = 72;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [WORK_W-1:0] work_t;
    typedef logic signed [VAL_W-1:0]  val_t;
    typedef logic signed [DER_W-1:0]  der_t;

    // Scale factors sqrt(2n+1) in Q.30, rounded to nearest.
    localparam logic signed [31:0] SQRT3_Q30 = 32'sd1859775393;
    localparam logic signed [33:0] SQRT5_Q30 = 34'sd2400959709;
    localparam logic signed [33:0] SQRT7_Q30 = 34'sd2840853839;

    localparam val_t ONE_Q28  = VAL_W'(64'sd1 <<< 28);
    localparam der_t DER1_Q28 = DER_W'((34'sd1859775393 + 34'sd2) >>> 2);

    typedef struct packed {
        val_t [POLY_N-1:0] val;
        der_t [POLY_N-1:0] der;
    } line_t;

    typedef struct packed {
        line_t xi;
        line_t eta;
    } qent_t;

    typedef struct packed {
        logic empty;
        logic full;
    } qstat_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] xi_coord;
        logic signed [COORD_W-1:0] eta_coord;
    } in_req_t;

    typedef struct packed {
        logic [IDX_W-1:0]        basis_index;
        logic signed [OUT_W-1:0] basis_value;
        logic signed [OUT_W-1:0] d_xi_value;
        logic signed [OUT_W-1:0] d_eta_value;
        logic                    last_flag;
    } out_req_t;

    // Divide by 2^s, rounding to nearest with ties towards plus infinity.
    function automatic work_t rnd_shr(input work_t v, input int unsigned s);
        work_t half;
        half = work_t'(1) <<< (s - 1);
        return (v + half) >>> s;
    endfunction

endpackage

// ===== rtl/legendre_tensor_basis_eval.sv =====
// Top level of the normalised Legendre tensor-product basis evaluator.
//
//   Channel   Direction  Handshake                    Request
//   in        input      in_valid / in_stall          in_data: xi_coord, eta_coord
//   out       output     out_valid / out_stall        out_data: one basis triple
//   cfg       input      cfg_wr_en (no wait)          cfg_wr_data: order_in_use
//
// One result leaves per cycle while a point is queued and out_stall is low; a point at
// order n yields (n+1)(n+2)/2 results from the back-end sequencer (15 at order four, one at order zero).
// A point passes through the front-end line pipeline, the queue and the product pipeline
// before its first result shows. Reset clears all control state at once; there is no
// clearing pass. A stalled result freezes the back end; the two-entry queue lets the
// front end keep taking requests until it fills.
`include "legendre_tensor_basis_eval_defines.svh"
module legendre_tensor_basis_eval
    import ltbe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  in_req_t            in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output out_req_t           out_data,
    input  logic               cfg_wr_en,
    input  logic [ORDER_W-1:0] cfg_wr_data
);

    logic [ORDER_W-1:0] order_reg, order_next;
    logic               q_push;
    logic               q_pop;
    qent_t              q_push_data;
    qent_t              q_head;
    qstat_t             qstat;

    function automatic logic [IDX_W-1:0] last_index(input logic [ORDER_W-1:0] n);
        logic [IDX_W-1:0] r;
        unique case (n)
            3'd0:    r = IDX_W'(0);
            3'd1:    r = IDX_W'(2);
            3'd2:    r = IDX_W'(5);
            3'd3:    r = IDX_W'(9);
            default: r = IDX_W'(14);
        endcase
        return r;
    endfunction

    // Orders above the maximum are stored as the maximum.
    always_comb
    begin
        order_next = order_reg;
        if (cfg_wr_en)
            order_next = (cfg_wr_data > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER)
                                                             : cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            order_reg <= ORDER_W'(MAX_ORDER);
        else
            order_reg <= order_next;
    end

    ltbe_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .qstat     (qstat),
        .push      (q_push),
        .push_data (q_push_data)
    );

    ltbe_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .head      (q_head),
        .qstat     (qstat)
    );

    ltbe_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .qstat     (qstat),
        .order     (order_reg),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    `LTBE_ASSERT_IMP(a_queue_no_overflow, clk, rst_n, q_push, !qstat.full)
    `LTBE_ASSERT_IMP(a_first_last, clk, rst_n, out_valid && (out_data.basis_index == '0), out_data.last_flag == (order_reg == '0))
    `LTBE_ASSERT_IMP(a_last_index, clk, rst_n, out_valid && out_data.last_flag, out_data.basis_index == last_index(order_reg))
    `LTBE_ASSERT_NEXT(a_index_step, clk, rst_n, out_valid && !out_stall && !out_data.last_flag, out_valid && (out_data.basis_index == $past(out_data.basis_index) + 1'b1))

endmodule

// ===== rtl/ltbe_line.sv =====
// Four-stage pipeline evaluating scaled Legendre values and slopes of one coordinate.
module ltbe_line
    import ltbe_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [COORD_W-1:0] coord,
    output line_t                     line
);

    localparam logic signed [34:0] T3_OFS = 35'sd805306368;   // 3 * 2^28
    localparam logic signed [35:0] T4_OFS = 36'sd4026531840;  // 15 * 2^28

    // Stage one: clamped coordinate.
    logic signed [COORD_W-1:0] x1_reg;

    // Stage two.
    logic signed [COORD_W-1:0] x2_reg, x2_next;
    logic signed [29:0]        sq2_reg, sq2_next;
    val_t                      v1_2_reg, v1_2_next;
    der_t                      d2_2_reg, d2_2_next;

    // Stage three.
    logic signed [29:0] sq3_reg, sq3_next;
    logic signed [59:0] sqsq3_reg, sqsq3_next;
    logic signed [31:0] p2_3_reg, p2_3_next;
    logic signed [31:0] p3_3_reg, p3_3_next;
    logic signed [32:0] q3_3_reg, q3_3_next;
    logic signed [33:0] q4_3_reg, q4_3_next;
    val_t               v1_3_reg;
    der_t               d2_3_reg;

    // Stage four.
    line_t line_reg, line_next;

    logic signed [31:0] sq_full;
    logic signed [47:0] mul_s3;
    logic signed [17:0] x_triple;
    logic signed [51:0] mul_s5;
    logic signed [34:0] t3;
    logic signed [35:0] t4;
    logic signed [50:0] mul_t3;
    logic signed [51:0] mul_t4;
    logic signed [65:0] mul_v2;
    logic signed [65:0] mul_v3;
    logic signed [66:0] mul_d3;
    work_t              sqsq_w, sq_w, poly4, p4, q4_w;

    always_comb
    begin
        sq_full   = x1_reg * x1_reg;
        mul_s3    = x1_reg * SQRT3_Q30;
        x_triple  = (18'(x1_reg) <<< 1) + 18'(x1_reg);
        mul_s5    = x_triple * SQRT5_Q30;
        x2_next   = x1_reg;
        sq2_next  = sq_full[29:0];
        v1_2_next = VAL_W'(rnd_shr(WORK_W'(mul_s3), 16));
        d2_2_next = DER_W'(rnd_shr(WORK_W'(mul_s5), 16));
    end

    always_comb
    begin
        t3 = (35'(sq2_reg) <<< 2) + 35'(sq2_reg) - T3_OFS;
        t4 = (36'(sq2_reg) <<< 5) + (36'(sq2_reg) <<< 1) + 36'(sq2_reg) - T4_OFS;
        mul_t3 = x2_reg * t3;
        mul_t4 = x2_reg * t4;
        sq3_next   = sq2_reg;
        sqsq3_next = 60'(sq2_reg) * 60'(sq2_reg);
        p3_3_next  = 32'(rnd_shr(WORK_W'(mul_t3), 15));
        q4_3_next  = 34'(rnd_shr(WORK_W'(mul_t4), 15));
        p2_3_next  = 32'(rnd_shr((WORK_W'(sq2_reg) <<< 1) + WORK_W'(sq2_reg)
                                 - (work_t'(1) <<< 28), 1));
        q3_3_next  = 33'(rnd_shr((WORK_W'(sq2_reg) <<< 4) - WORK_W'(sq2_reg)
                                 - WORK_W'(T3_OFS), 1));
    end

    always_comb
    begin
        mul_v2 = p2_3_reg * SQRT5_Q30;
        mul_v3 = p3_3_reg * SQRT7_Q30;
        mul_d3 = q3_3_reg * SQRT7_Q30;
        sqsq_w = WORK_W'(sqsq3_reg);
        sq_w   = WORK_W'(sq3_reg);
        // 35*x^4 - 30*x^2 + 3, all scaled to Q.56.
        poly4  = (sqsq_w <<< 5) + (sqsq_w <<< 1) + sqsq_w
               - (sq_w <<< 33) + (sq_w <<< 29) + (work_t'(3) <<< 56);
        p4     = rnd_shr(poly4, 31);
        q4_w   = WORK_W'(q4_3_reg);

        line_next.val[0] = ONE_Q28;
        line_next.val[1] = v1_3_reg;
        line_next.val[2] = VAL_W'(rnd_shr(WORK_W'(mul_v2), 30));
        line_next.val[3] = VAL_W'(rnd_shr(WORK_W'(mul_v3), 30));
        line_next.val[4] = VAL_W'((p4 <<< 1) + p4);
        line_next.der[0] = '0;
        line_next.der[1] = DER1_Q28;
        line_next.der[2] = d2_3_reg;
        line_next.der[3] = DER_W'(rnd_shr(WORK_W'(mul_d3), 30));
        line_next.der[4] = DER_W'((q4_w <<< 1) + q4_w);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg    <= coord;
            x2_reg    <= x2_next;
            sq2_reg   <= sq2_next;
            v1_2_reg  <= v1_2_next;
            d2_2_reg  <= d2_2_next;
            sq3_reg   <= sq3_next;
            sqsq3_reg <= sqsq3_next;
            p2_3_reg  <= p2_3_next;
            p3_3_reg  <= p3_3_next;
            q3_3_reg  <= q3_3_next;
            q4_3_reg  <= q4_3_next;
            v1_3_reg  <= v1_2_reg;
            d2_3_reg  <= d2_2_reg;
            line_reg  <= line_next;
        end
    end

    assign line = line_reg;

endmodule

// ===== rtl/ltbe_front.sv =====
// Front end: takes requests, clamps the coordinates and evaluates both 1-D lines.
module ltbe_front
    import ltbe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  in_req_t in_data,
    input  qstat_t  qstat,
    output logic    push,
    output qent_t   push_data
);

    localparam int FRONT_STAGES = 4;

    logic [FRONT_STAGES-1:0] vld_reg, vld_next;
    logic                    en;
    logic signed [COORD_W-1:0] xi_clamped, eta_clamped;

    function automatic logic signed [COORD_W-1:0] clamp_coord(
        input logic signed [COORD_W-1:0] c
    );
        logic signed [COORD_W-1:0] hi;
        logic signed [COORD_W-1:0] lo;
        hi = COORD_W'(16384);
        lo = -hi;
        if (c > hi)
            return hi;
        else if (c < lo)
            return lo;
        else
            return c;
    endfunction

    // The whole pipeline holds only when a finished request finds the queue full.
    assign en       = !(vld_reg[FRONT_STAGES-1] && qstat.full);
    assign in_stall = !en;
    assign push     = vld_reg[FRONT_STAGES-1] && !qstat.full;

    assign xi_clamped  = clamp_coord(in_data.xi_coord);
    assign eta_clamped = clamp_coord(in_data.eta_coord);

    always_comb
    begin
        vld_next = vld_reg;
        if (en)
            vld_next = {vld_reg[FRONT_STAGES-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    ltbe_line u_xi_line
    (
        .clk   (clk),
        .en    (en),
        .coord (xi_clamped),
        .line  (push_data.xi)
    );

    ltbe_line u_eta_line
    (
        .clk   (clk),
        .en    (en),
        .coord (eta_clamped),
        .line  (push_data.eta)
    );

endmodule

// ===== rtl/ltbe_queue.sv =====
// Short queue of evaluated points between the front end and the back end.
module ltbe_queue
    import ltbe_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  qent_t  push_data,
    input  logic   pop,
    output qent_t  head,
    output qstat_t qstat
);

    qent_t                  mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_reg, wr_next;
    logic [QUEUE_PTR_W-1:0] rd_reg, rd_next;
    logic [QUEUE_CNT_W-1:0] cnt_reg, cnt_next;

    // The depth is a power of two, so the pointers simply wrap.
    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop  ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        unique case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

    assign head        = mem_reg[rd_reg];
    assign qstat.empty = (cnt_reg == '0);
    assign qstat.full  = (cnt_reg == QUEUE_CNT_W'(QUEUE_DEPTH));

endmodule

// ===== rtl/ltbe_back.sv =====
// Back end: walks the total-degree order and forms the tensor products.
module ltbe_back
    import ltbe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  qent_t              head,
    input  qstat_t             qstat,
    input  logic [ORDER_W-1:0] order,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output out_req_t           out_data
);

    logic [ORDER_W-1:0] i_reg, i_next;
    logic [ORDER_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               vld1_reg, vld1_next;
    logic               vld2_reg, vld2_next;
    logic               out_valid_reg, out_valid_next;

    val_t               vx1_reg, ve1_reg;
    der_t               dx1_reg, de1_reg;
    logic [IDX_W-1:0]   idx1_reg, idx2_reg;
    logic               last1_reg, last2_reg;
    logic signed [61:0] pv2_reg;
    logic signed [64:0] pdx2_reg, pde2_reg;
    out_req_t           out_reg, out_next;

    logic                  en;
    logic                  issue;
    logic                  seq_last;
    logic [ORDER_W-1:0]    m_ord;
    logic [POLY_SEL_W-1:0] sel_k, sel_m;

    // Every stage moves together; only a waiting result holds them.
    assign en       = !(out_valid_reg && out_stall);
    assign issue    = en && !qstat.empty;
    assign seq_last = (i_reg == order) && (k_reg == '0);
    assign pop      = issue && seq_last;
    assign m_ord    = i_reg - k_reg;
    assign sel_k    = POLY_SEL_W'(k_reg);
    assign sel_m    = POLY_SEL_W'(m_ord);

    always_comb
    begin
        i_next   = i_reg;
        k_next   = k_reg;
        idx_next = idx_reg;
        if (issue)
        begin
            if (seq_last)
            begin
                i_next   = '0;
                k_next   = '0;
                idx_next = '0;
            end
            else if (k_reg == '0)
            begin
                // Next degree starts with the highest xi order.
                i_next   = i_reg + 1'b1;
                k_next   = i_reg + 1'b1;
                idx_next = idx_reg + 1'b1;
            end
            else
            begin
                k_next   = k_reg - 1'b1;
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        vld1_next      = en ? issue    : vld1_reg;
        vld2_next      = en ? vld1_reg : vld2_reg;
        out_valid_next = en ? vld2_reg : out_valid_reg;

        out_next.basis_index = idx2_reg;
        out_next.basis_value = OUT_W'(rnd_shr(WORK_W'(pv2_reg), 40));
        out_next.d_xi_value  = OUT_W'(rnd_shr(WORK_W'(pdx2_reg), 40));
        out_next.d_eta_value = OUT_W'(rnd_shr(WORK_W'(pde2_reg), 40));
        out_next.last_flag   = last2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg         <= '0;
            k_reg         <= '0;
            idx_reg       <= '0;
            vld1_reg      <= 1'b0;
            vld2_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            i_reg         <= i_next;
            k_reg         <= k_next;
            idx_reg       <= idx_next;
            vld1_reg      <= vld1_next;
            vld2_reg      <= vld2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vx1_reg   <= head.xi.val[sel_k];
            dx1_reg   <= head.xi.der[sel_k];
            ve1_reg   <= head.eta.val[sel_m];
            de1_reg   <= head.eta.der[sel_m];
            idx1_reg  <= idx_reg;
            last1_reg <= seq_last;
            pv2_reg   <= vx1_reg * ve1_reg;
            pdx2_reg  <= dx1_reg * ve1_reg;
            pde2_reg  <= vx1_reg * de1_reg;
            idx2_reg  <= idx1_reg;
            last2_reg <= last1_reg;
            out_reg   <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the Legendre tensor basis evaluator, with its own fixed-point predictor.
module testbench;
    import ltbe_pkg::*;

    localparam int HALF_PERIOD      = 5;
    localparam int SETTLE_CYCLES    = 12;
    localparam int DRAIN_CYCLES     = 20;
    localparam int STUCK_LIMIT      = 2000;
    localparam int LONG_HOLD_AFTER  = 200;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int FREE_FLOW_FROM   = 100;
    localparam int FREE_FLOW_TO     = 140;
    localparam int PHASE_POINTS     = 54;
    localparam int MAX_PRINTS       = 100;

    localparam longint UNIT_Q28  = 64'sd1 <<< 28;
    localparam longint ROOT3_Q30 = 64'sd1859775393;
    localparam longint ROOT5_Q30 = 64'sd2400959709;
    localparam longint ROOT7_Q30 = 64'sd2840853839;

    typedef enum logic [1:0] {STEP_POINT, STEP_SETTLE, STEP_ORDER} step_kind_e;

    typedef struct packed {
        step_kind_e         kind;
        in_req_t            point;
        logic [ORDER_W-1:0] order;
        int unsigned        gap;
    } drive_step_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_req_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_req_t out_data;
    logic cfg_wr_en = 1'b0;
    logic [ORDER_W-1:0] cfg_wr_data = 3'd4;

    drive_step_t drive_plan_q[$];
    out_req_t expected_basis_q[$];
    logic [ORDER_W-1:0] active_order = 3'd4;
    logic in_fired = 1'b0;
    logic stimulus_done = 1'b0;
    logic settling = 1'b0;
    int unsigned gap_left = 0;
    int unsigned settle_left = 0;
    int unsigned points_taken = 0;
    int unsigned results_seen = 0;
    int unsigned clamped_points = 0;
    int unsigned mismatch_count = 0;
    int unsigned stuck_cycles = 0;
    int unsigned stall_run_left = 0;
    int unsigned long_hold_left = 0;
    logic long_hold_done = 1'b0;

    legendre_tensor_basis_eval dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Divide by 2^s, rounding to nearest with ties upwards.
    function automatic longint shift_round_up(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_coord(input logic signed [COORD_W-1:0] raw);
        longint c;
        c = raw;
        if (c > 16384)
            c = 16384;
        if (c < -16384)
            c = -16384;
        return c;
    endfunction

    // Scaled Legendre value or derivative of one degree, in Q.28, for x = c / 2^14.
    function automatic longint legendre_q28(input longint c, input int deg, input bit slope);
        longint c2;
        c2 = c * c;
        case (deg)
            0: return slope ? 64'sd0 : UNIT_Q28;
            1: return slope ? shift_round_up(ROOT3_Q30, 2)
                            : shift_round_up(c * 16384 * ROOT3_Q30, 30);
            2: return slope ? shift_round_up(3 * c * 16384 * ROOT5_Q30, 30)
                            : shift_round_up(shift_round_up(3 * c2 - UNIT_Q28, 1) * ROOT5_Q30, 30);
            3: return slope
                ? shift_round_up(shift_round_up(15 * c2 - 3 * UNIT_Q28, 1) * ROOT7_Q30, 30)
                : shift_round_up(shift_round_up(c * (5 * c2 - 3 * UNIT_Q28), 15) * ROOT7_Q30, 30);
            default: return slope
                ? 3 * shift_round_up(c * (35 * c2 - 15 * UNIT_Q28), 15)
                : 3 * shift_round_up(35 * c2 * c2 - 30 * UNIT_Q28 * c2
                                     + 3 * UNIT_Q28 * UNIT_Q28, 31);
        endcase
    endfunction

    // Queue the whole total-degree basis that one accepted point must produce.
    task automatic predict_basis_set(input in_req_t pt, input logic [ORDER_W-1:0] order_reg);
        longint xc;
        longint ec;
        int top;
        int total;
        int idx;
        out_req_t r;
        xc = clamp_coord(pt.xi_coord);
        ec = clamp_coord(pt.eta_coord);
        top = (order_reg > MAX_ORDER) ? MAX_ORDER : int'(order_reg);
        total = (top + 1) * (top + 2) / 2;
        idx = 0;
        for (int deg = 0; deg <= top; deg++)
        begin
            for (int k = deg; k >= 0; k--)
            begin
                r.basis_index = idx[IDX_W-1:0];
                r.basis_value = OUT_W'(shift_round_up(
                    legendre_q28(xc, k, 1'b0) * legendre_q28(ec, deg - k, 1'b0), 40));
                r.d_xi_value = OUT_W'(shift_round_up(
                    legendre_q28(xc, k, 1'b1) * legendre_q28(ec, deg - k, 1'b0), 40));
                r.d_eta_value = OUT_W'(shift_round_up(
                    legendre_q28(xc, k, 1'b0) * legendre_q28(ec, deg - k, 1'b1), 40));
                r.last_flag = (idx + 1 == total);
                expected_basis_q.push_back(r);
                idx++;
            end
        end
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_coord();
        int unsigned r;
        int v;
        r = $urandom_range(99);
        if (r < 70)
        begin
            v = int'($urandom_range(32768)) - 16384;
            return v[COORD_W-1:0];
        end
        else if (r < 85)
            return COORD_W'($urandom);
        case ($urandom_range(6))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sd16383;
            3: return -16'sd16383;
            4: return 16'sd0;
            5: return 16'sd32767;
            default: return -16'sd32768;
        endcase
    endfunction

    task automatic add_point(input logic signed [COORD_W-1:0] xi, eta, input int unsigned gap);
        drive_step_t s;
        s = '0;
        s.kind = STEP_POINT;
        s.point.xi_coord = xi;
        s.point.eta_coord = eta;
        s.gap = gap;
        drive_plan_q.push_back(s);
    endtask

    // An order change always waits until the block has emptied.
    task automatic add_settle_and_order(input logic [ORDER_W-1:0] order_val, input bit write_it);
        drive_step_t s;
        s = '0;
        s.kind = STEP_SETTLE;
        drive_plan_q.push_back(s);
        if (write_it)
        begin
            s.kind = STEP_ORDER;
            s.order = order_val;
            drive_plan_q.push_back(s);
        end
    endtask

    // Request driver: one step of the plan at a time, changes only at the falling edge.
    always @(negedge clk)
    begin
        drive_step_t step;
        logic next_valid;
        logic next_wr;
        next_valid = in_valid;
        next_wr = 1'b0;
        if (rst_n)
        begin
            if (in_fired)
                next_valid = 1'b0;
            if (!next_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (settling)
                begin
                    if (expected_basis_q.size() == 0)
                    begin
                        if (settle_left > 0)
                            settle_left--;
                        else
                            settling = 1'b0;
                    end
                end
                else if (drive_plan_q.size() > 0)
                begin
                    step = drive_plan_q.pop_front();
                    case (step.kind)
                        STEP_POINT:
                        begin
                            next_valid = 1'b1;
                            in_data <= step.point;
                            gap_left = step.gap;
                        end
                        STEP_SETTLE:
                        begin
                            settling = 1'b1;
                            settle_left = SETTLE_CYCLES;
                        end
                        default:
                        begin
                            next_wr = 1'b1;
                            cfg_wr_data <= step.order;
                        end
                    endcase
                end
                else
                    stimulus_done = 1'b1;
            end
        end
        in_valid <= next_valid;
        cfg_wr_en <= next_wr;
    end

    // Result receiver stall pattern, with one long hold-off while requests keep coming.
    always @(negedge clk)
    begin
        logic next_stall;
        int unsigned r;
        next_stall = out_stall;
        if (long_hold_left > 0)
        begin
            long_hold_left--;
            next_stall = 1'b1;
        end
        else if (!long_hold_done && points_taken >= LONG_HOLD_AFTER && in_valid)
        begin
            long_hold_done = 1'b1;
            long_hold_left = LONG_HOLD_CYCLES - 1;
            next_stall = 1'b1;
        end
        else if (points_taken >= FREE_FLOW_FROM && points_taken < FREE_FLOW_TO)
            next_stall = 1'b0;
        else if (stall_run_left > 0)
            stall_run_left--;
        else
        begin
            r = $urandom_range(99);
            if (r < 60)
            begin
                next_stall = 1'b0;
                stall_run_left = $urandom_range(7);
            end
            else if (r < 92)
            begin
                next_stall = 1'b1;
                stall_run_left = $urandom_range(2);
            end
            else
            begin
                next_stall = 1'b1;
                stall_run_left = $urandom_range(30, 8);
            end
        end
        out_stall <= next_stall;
    end

    // Monitor: predicts on every accepted request and checks every accepted result.
    always @(posedge clk)
    begin
        out_req_t want;
        if (rst_n)
        begin
            in_fired <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                predict_basis_set(in_data, active_order);
                if (clamp_coord(in_data.xi_coord) != in_data.xi_coord
                    || clamp_coord(in_data.eta_coord) != in_data.eta_coord)
                    clamped_points++;
                points_taken++;
            end
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_basis_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_PRINTS)
                        $display("%0t: unexpected result, expected none, got idx %0d val %0d",
                                 $time, out_data.basis_index, out_data.basis_value);
                end
                else
                begin
                    want = expected_basis_q.pop_front();
                    if (out_data !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_PRINTS)
                            $display({"%0t: basis mismatch, expected idx %0d val %0d dxi %0d ",
                                      "deta %0d last %0b, got idx %0d val %0d dxi %0d ",
                                      "deta %0d last %0b"}, $time,
                                     want.basis_index, want.basis_value, want.d_xi_value,
                                     want.d_eta_value, want.last_flag,
                                     out_data.basis_index, out_data.basis_value,
                                     out_data.d_xi_value, out_data.d_eta_value,
                                     out_data.last_flag);
                    end
                end
            end
            if (cfg_wr_en)
                active_order = cfg_wr_data;
        end
    end

    // Watchdog on cycles in which neither channel moves a request.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles, %0d results outstanding",
                         $time, STUCK_LIMIT, expected_basis_q.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        logic [ORDER_W-1:0] phase_orders [9] = '{3'd3, 3'd1, 3'd5, 3'd2, 3'd6,
                                                  3'd4, 3'd0, 3'd7, 3'd4};

        // Directed points at the reset order: corners, clamping, tiny and mid values.
        add_point(16'sd0, 16'sd0, 0);
        add_point(16'sd16384, 16'sd16384, 0);
        add_point(-16'sd16384, -16'sd16384, 0);
        add_point(16'sd16384, -16'sd16384, 0);
        add_point(-16'sd16384, 16'sd16384, 0);
        add_point(16'sd32767, -16'sd32768, 0);
        add_point(-16'sd32768, 16'sd32767, 0);
        add_point(16'sd16385, -16'sd16385, 0);
        add_point(16'sd1, -16'sd1, 0);
        add_point(-16'sd1, 16'sd1, 0);
        add_point(16'sd8192, -16'sd8192, 0);
        add_point(16'sd9459, -16'sd9459, 0);
        // Order zero gives a single constant function.
        add_settle_and_order(3'd0, 1'b1);
        add_point(16'sd0, 16'sd0, 0);
        add_point(16'sd16384, -16'sd16384, 0);
        add_point(-16'sd32768, 16'sd32767, 0);
        // Register values above the maximum behave as the maximum.
        add_settle_and_order(3'd7, 1'b1);
        add_point(16'sd16384, 16'sd16384, 0);
        add_point(-16'sd5000, 16'sd12000, 0);

        foreach (phase_orders[p])
        begin
            add_settle_and_order(phase_orders[p], 1'b1);
            for (int n = 0; n < PHASE_POINTS; n++)
                add_point(pick_coord(), pick_coord(), pick_gap());
        end
        add_settle_and_order(3'd0, 1'b0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (stimulus_done);
        while (expected_basis_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d results from %0d points (%0d clamped) over order settings 0 to 7.",
                 results_seen, points_taken, clamped_points);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
